FILE: sv/vmf_pkg.sv
package vmf_pkg;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 2'd2;

  // Register field widths and reset values.
  localparam int RAW_W_W = 11;
  localparam int RAW_H_W = 13;
  localparam int R_W     = 3;
  localparam logic [RAW_W_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [RAW_H_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [R_W-1:0]     RST_RADIUS = 3'd1;

  // Height saturation and the width of a height or row number.
  localparam int HEIGHT_LIMIT = 4096;
  localparam int H_W          = 13;

  // Window side in pixels fits four bits for a three-bit radius.
  localparam int DIM_W = 4;

  // Pixel packing: blue in the top byte, red in the bottom byte.
  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  // Distance arithmetic: squared distance, rounded 9.8 root, 24.8 sums.
  localparam int D2_W     = 18;
  localparam int ROOT_W   = 17;
  localparam int SQ_STEPS = 17;
  localparam int SQ_LAT   = SQ_STEPS + 2;
  localparam int SUM_W    = 32;

  // Default sizing of the top level.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 4;

  // One slot of the candidate chain.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pix;
    logic [SUM_W-1:0] sum;
  } chain_t;

  // A window pixel that travels along the chain to every candidate.
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pix;
  } probe_t;

  // Controls common to all cells.
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: sv/vmf_sqrt.sv
module vmf_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [vmf_pkg::D2_W-1:0]   d2_i,
  output logic                       out_valid_o,
  output logic [vmf_pkg::ROOT_W-1:0] root_o
);
  import vmf_pkg::*;

  localparam int N_W   = 2 * SQ_STEPS;
  localparam int REM_W = ROOT_W + 3;

  logic              v_q [SQ_STEPS+1];
  logic [N_W-1:0]    n_q [SQ_STEPS+1];
  logic [ROOT_W-1:0] q_q [SQ_STEPS+1];
  logic [REM_W-1:0]  r_q [SQ_STEPS+1];
  logic              out_v_q;
  logic [ROOT_W-1:0] root_q;

  // Input stage: the radicand is the squared distance with 16 fraction bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q[0] <= {d2_i, {(N_W-D2_W){1'b0}}};
    q_q[0] <= '0;
    r_q[0] <= '0;
  end

  // One root bit per stage, taken from the next pair of radicand bits.
  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;

    always_comb begin
      r2    = {r_q[s][REM_W-3:0], n_q[s][N_W-1 -: 2]};
      trial = REM_W'({q_q[s], 2'b01});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[s+1] <= {n_q[s][N_W-3:0], 2'b00};
      if (r2 >= trial) begin
        r_q[s+1] <= r2 - trial;
        q_q[s+1] <= {q_q[s][ROOT_W-2:0], 1'b1};
      end else begin
        r_q[s+1] <= r2;
        q_q[s+1] <= {q_q[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the floor root.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= v_q[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_q[SQ_STEPS] > REM_W'(q_q[SQ_STEPS])) begin
      root_q <= q_q[SQ_STEPS] + ROOT_W'(1);
    end else begin
      root_q <= q_q[SQ_STEPS];
    end
  end

  assign out_valid_o = out_v_q;
  assign root_o      = root_q;

endmodule

FILE: sv/vmf_cell.sv
module vmf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vmf_pkg::cell_ctl_t ctl_i,
  input  vmf_pkg::chain_t    chain_i,
  output vmf_pkg::chain_t    chain_o,
  input  vmf_pkg::probe_t    probe_i,
  output vmf_pkg::probe_t    probe_o
);
  import vmf_pkg::*;

  logic              cand_v_q;
  logic [PIX_W-1:0]  cand_pix_q;
  logic [SUM_W-1:0]  sum_q;
  logic              probe_v_q;
  logic [PIX_W-1:0]  probe_pix_q;
  logic              pair_v_q;
  logic [D2_W-1:0]   d2_q;
  logic [D2_W-1:0]   d2_d;
  logic              root_v;
  logic [ROOT_W-1:0] root;

  // Candidate slot: cleared before a window, shifted in and out along the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_v_q <= 1'b0;
    end else if (ctl_i.clear) begin
      cand_v_q <= 1'b0;
    end else if (ctl_i.shift) begin
      cand_v_q <= chain_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      cand_pix_q <= chain_i.pix;
    end
    if (ctl_i.clear) begin
      sum_q <= '0;
    end else if (ctl_i.shift) begin
      sum_q <= chain_i.sum;
    end else if (root_v) begin
      sum_q <= sum_q + SUM_W'(root);
    end
  end

  // Probe register, handed to the next cell in the following cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_v_q <= 1'b0;
    end else begin
      probe_v_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_pix_q <= probe_i.pix;
  end

  // Squared color distance between the candidate and the probe.
  always_comb begin
    logic [CH_W-1:0] ad;
    d2_d = '0;
    for (int c = 0; c < 3; c++) begin
      if (cand_pix_q[c*CH_W +: CH_W] > probe_pix_q[c*CH_W +: CH_W]) begin
        ad = cand_pix_q[c*CH_W +: CH_W] - probe_pix_q[c*CH_W +: CH_W];
      end else begin
        ad = probe_pix_q[c*CH_W +: CH_W] - cand_pix_q[c*CH_W +: CH_W];
      end
      d2_d = d2_d + D2_W'(ad) * D2_W'(ad);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_v_q <= 1'b0;
    end else begin
      pair_v_q <= probe_v_q && cand_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q <= d2_d;
  end

  vmf_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pair_v_q),
    .d2_i        (d2_q),
    .out_valid_o (root_v),
    .root_o      (root)
  );

  assign chain_o.valid = cand_v_q;
  assign chain_o.pix   = cand_pix_q;
  assign chain_o.sum   = sum_q;
  assign probe_o.valid = probe_v_q;
  assign probe_o.pix   = probe_pix_q;

endmodule

FILE: sv/vector_median_filter_unit.sv
// Vector median filter over RGB pixels in raster order.
//
// The input stream carries one pixel per beat (tdata: red, green, blue) and
// a mode flag in tuser: 0 for a pixel, 1 for a flush beat. Output k leaves on
// the pixel beat that brings pixel k + R*W + R; once the frame is complete,
// flush beats release the remaining outputs, and tlast marks the last pixel.
// Registers (width, height, radius) are to be written on the cfg channel while the
// block is idle, which it does not enforce; a register write restarts the frame.
//
// Each output takes its steps in order: the setup states compute the clipped
// window, its candidates load from the line store, the window streams past them,
// the row pipeline drains, the sums shift out to the minimum search and the
// output register fills. The input then reopens; beats that produce no output
// do not close it. One item is in work at a time; the line store read port sets
// the load and probe times.
// After reset the counts are zero and the registers hold 640 x 480, radius 1.
// A finished result waits in the output register while the receiver stalls;
// the block still takes beats, and a next result waits until it is taken.
module vector_median_filter_unit #(
  parameter int MAX_WIDTH  = vmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = vmf_pkg::DEF_MAX_RADIUS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [vmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                          s_axis_tuser,  // mode
  // Filtered output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red_out, green_out, blue_out
  output logic                          m_axis_tlast   // last_of_frame
);
  import vmf_pkg::*;

  localparam int DEPTH = 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int AXW   = ((AW > WW) ? AW : WW) + 1;
  localparam int BW    = AXW + R_W;
  localparam int CNT_W = WW + H_W;
  localparam int NCELL = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int DRAIN = NCELL + SQ_LAT + 4;
  localparam int SC_W  = $clog2(DRAIN + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP1 = 3'd1;
  localparam logic [2:0] ST_SETUP2 = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_PROBE  = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_SCAN   = 3'd6;
  localparam logic [2:0] ST_WAIT   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [RAW_W_W-1:0] w_raw_q;
  logic [RAW_H_W-1:0] h_raw_q;
  logic [R_W-1:0]     r_raw_q;
  logic               cfg_pend_q;
  logic [WW-1:0]      w_eff;
  logic [H_W-1:0]     h_eff;
  logic [R_W-1:0]     r_eff;
  logic [CNT_W-1:0]   total_q;
  logic [CNT_W-1:0]   lag_q;
  logic [CNT_W-1:0]   in_cnt_q, out_cnt_q;
  logic [AW-1:0]      in_ptr_q, out_ptr_q;
  logic [WW-1:0]      out_x_q;
  logic [H_W-1:0]     out_y_q;
  logic [R_W-1:0]     rlo_y_q, rhi_y_q, rlo_x_q, rhi_x_q;
  logic [DIM_W-1:0]   nrows_q, ncols_q, rc_q, cc_q;
  logic [AW-1:0]      start_q, base_q;
  logic [AW-1:0]      addr_cur, base_nx, start_d;
  logic [SC_W-1:0]    cnt_q;
  logic [PIX_W-1:0]   mem [DEPTH];
  logic [PIX_W-1:0]   rd_q;
  logic               rd_load_q, rd_probe_q;
  logic               have_q;
  logic [SUM_W-1:0]   best_sum_q;
  logic [PIX_W-1:0]   best_pix_q;
  logic               out_v_q;
  logic [PIX_W-1:0]   out_pix_q;
  logic               out_last_q;
  logic               in_acc, cfg_acc, cfg_hit, px_write, emit_go, issue_last, finish;
  logic [CNT_W-1:0]   out_nx;
  cell_ctl_t          ctl;
  chain_t             chain_w [NCELL+1];
  probe_t             probe_w [NCELL+1];
  chain_t             tail;

  // Effective register values after clamping.
  always_comb begin
    if (w_raw_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(w_raw_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw_q);
    end
    if (h_raw_q == '0) begin
      h_eff = H_W'(1);
    end else if (int'(h_raw_q) > HEIGHT_LIMIT) begin
      h_eff = H_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = h_raw_q;
    end
    if (int'(r_raw_q) > MAX_RADIUS) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = r_raw_q;
    end
  end

  // Configuration registers; the input closes in the cycle after a write.
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_acc && (cfg_index_i == CFG_IMAGE_WIDTH ||
                                   cfg_index_i == CFG_IMAGE_HEIGHT ||
                                   cfg_index_i == CFG_WINDOW_RADIUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_raw_q    <= RST_WIDTH;
      h_raw_q    <= RST_HEIGHT;
      r_raw_q    <= RST_RADIUS;
      cfg_pend_q <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_acc;
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:   w_raw_q <= cfg_data_i[RAW_W_W-1:0];
          CFG_IMAGE_HEIGHT:  h_raw_q <= cfg_data_i[RAW_H_W-1:0];
          CFG_WINDOW_RADIUS: r_raw_q <= cfg_data_i[R_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Frame size and output lag are registered from the clamped register values.
  always_ff @(posedge clk_i) begin
    total_q <= CNT_W'(w_eff) * CNT_W'(h_eff);
    lag_q   <= CNT_W'(r_eff) * CNT_W'(w_eff) + CNT_W'(r_eff);
  end

  // Input acceptance and the emit decision.
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_pend_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign px_write      = in_acc && !s_axis_tuser && (in_cnt_q < total_q);

  always_comb begin
    emit_go = 1'b0;
    if (in_acc) begin
      if (px_write) begin
        emit_go = ((CNT_W+1)'(out_cnt_q) + (CNT_W+1)'(lag_q) <
                   (CNT_W+1)'(in_cnt_q) + (CNT_W+1)'(1)) && (out_cnt_q < total_q);
      end else begin
        emit_go = (in_cnt_q >= total_q) && (out_cnt_q < total_q);
      end
    end
  end

  assign finish = (state_q == ST_WAIT) && !out_v_q;
  assign out_nx = out_cnt_q + CNT_W'(1);

  // Frame counters and ring pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      in_ptr_q  <= '0;
      out_ptr_q <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
    end else if (cfg_hit) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      in_ptr_q  <= '0;
      out_ptr_q <= '0;
      out_x_q   <= '0;
      out_y_q   <= '0;
    end else begin
      if (px_write) begin
        in_cnt_q <= in_cnt_q + CNT_W'(1);
        if (int'(in_ptr_q) == DEPTH - 1) begin
          in_ptr_q <= '0;
        end else begin
          in_ptr_q <= in_ptr_q + AW'(1);
        end
      end
      if (finish) begin
        if (out_nx >= total_q) begin
          in_cnt_q  <= '0;
          out_cnt_q <= '0;
          in_ptr_q  <= '0;
          out_ptr_q <= '0;
          out_x_q   <= '0;
          out_y_q   <= '0;
        end else begin
          out_cnt_q <= out_nx;
          if (int'(out_ptr_q) == DEPTH - 1) begin
            out_ptr_q <= '0;
          end else begin
            out_ptr_q <= out_ptr_q + AW'(1);
          end
          if (out_x_q + WW'(1) == w_eff) begin
            out_x_q <= '0;
            out_y_q <= out_y_q + H_W'(1);
          end else begin
            out_x_q <= out_x_q + WW'(1);
          end
        end
      end
    end
  end

  // Line store: written by pixel beats, read while the window is walked.
  always_ff @(posedge clk_i) begin
    if (px_write) begin
      mem[in_ptr_q] <= s_axis_tdata[23:0] == '0 ? '0 :
                       {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end
    rd_q <= mem[addr_cur];
  end

  // Window address arithmetic, modulo the ring depth.
  always_comb begin
    logic [AXW-1:0] a_sum;
    logic [AXW-1:0] b_sum;
    logic [BW-1:0]  back;
    a_sum = AXW'(base_q) + AXW'(cc_q);
    if (a_sum >= AXW'(DEPTH)) begin
      a_sum = a_sum - AXW'(DEPTH);
    end
    addr_cur = a_sum[AW-1:0];
    b_sum = AXW'(base_q) + AXW'(w_eff);
    if (b_sum >= AXW'(DEPTH)) begin
      b_sum = b_sum - AXW'(DEPTH);
    end
    base_nx = b_sum[AW-1:0];
    back = BW'(rlo_y_q) * BW'(w_eff) + BW'(rlo_x_q);
    if (BW'(out_ptr_q) < back) begin
      start_d = AW'(BW'(out_ptr_q) + BW'(DEPTH) - back);
    end else begin
      start_d = AW'(BW'(out_ptr_q) - back);
    end
  end

  assign issue_last = (rc_q == nrows_q - DIM_W'(1)) && (cc_q == ncols_q - DIM_W'(1));

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (emit_go) state_d = ST_SETUP1;
      ST_SETUP1: state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_LOAD;
      ST_LOAD:   if (issue_last) state_d = ST_PROBE;
      ST_PROBE:  if (issue_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (int'(cnt_q) == DRAIN - 1) state_d = ST_SCAN;
      ST_SCAN:   if (int'(cnt_q) == NCELL - 1) state_d = ST_WAIT;
      ST_WAIT:   if (!out_v_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rd_load_q  <= 1'b0;
      rd_probe_q <= 1'b0;
      have_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_load_q  <= (state_q == ST_LOAD);
      rd_probe_q <= (state_q == ST_PROBE);
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + SC_W'(1);
      end
      if (state_q == ST_DRAIN) begin
        have_q <= 1'b0;
      end else if (state_q == ST_SCAN && tail.valid &&
                   (!have_q || tail.sum < best_sum_q)) begin
        have_q <= 1'b1;
      end
    end
  end

  // Window bounds, clipped at the frame edges, and the walk counters.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETUP1) begin
      rlo_y_q <= (out_y_q < H_W'(r_eff)) ? R_W'(out_y_q) : r_eff;
      rhi_y_q <= (h_eff - H_W'(1) - out_y_q < H_W'(r_eff)) ?
                 R_W'(h_eff - H_W'(1) - out_y_q) : r_eff;
      rlo_x_q <= (out_x_q < WW'(r_eff)) ? R_W'(out_x_q) : r_eff;
      rhi_x_q <= (w_eff - WW'(1) - out_x_q < WW'(r_eff)) ?
                 R_W'(w_eff - WW'(1) - out_x_q) : r_eff;
    end
    if (state_q == ST_SETUP2) begin
      nrows_q <= DIM_W'(rlo_y_q) + DIM_W'(rhi_y_q) + DIM_W'(1);
      ncols_q <= DIM_W'(rlo_x_q) + DIM_W'(rhi_x_q) + DIM_W'(1);
      start_q <= start_d;
      base_q  <= start_d;
      rc_q    <= '0;
      cc_q    <= '0;
    end else if (state_q == ST_LOAD || state_q == ST_PROBE) begin
      if (issue_last) begin
        base_q <= start_q;
        rc_q   <= '0;
        cc_q   <= '0;
      end else if (cc_q == ncols_q - DIM_W'(1)) begin
        base_q <= base_nx;
        rc_q   <= rc_q + DIM_W'(1);
        cc_q   <= '0;
      end else begin
        cc_q <= cc_q + DIM_W'(1);
      end
    end
    if (state_q == ST_SCAN && tail.valid && (!have_q || tail.sum < best_sum_q)) begin
      best_sum_q <= tail.sum;
      best_pix_q <= tail.pix;
    end
  end

  // Cell row: candidates enter at the head and leave at the tail in order.
  assign ctl.clear      = (state_q == ST_SETUP2);
  assign ctl.shift      = rd_load_q || (state_q == ST_SCAN);
  assign chain_w[0].valid = rd_load_q;
  assign chain_w[0].pix   = rd_q;
  assign chain_w[0].sum   = '0;
  assign probe_w[0].valid = rd_probe_q;
  assign probe_w[0].pix   = rd_q;
  assign tail             = chain_w[NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    vmf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .chain_i (chain_w[i]),
      .chain_o (chain_w[i+1]),
      .probe_i (probe_w[i]),
      .probe_o (probe_w[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (finish) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_pix_q  <= best_pix_q;
      out_last_q <= (out_nx == total_q) && (probe_w[NCELL].valid || 1'b1);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_pix_q[7:0], out_pix_q[15:8], out_pix_q[23:16]};
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: sv/vmf_checker.sv
module vmf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [vmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [vmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [23:0]                   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [23:0]                   m_axis_tdata,
  input logic                          m_axis_tlast
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // Input stays closed in the cycle after a register write.
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("input accepted right after a register write");

  // Results are far apart: a taken beat is never followed at once by another.
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back to back output beats");

endmodule

bind vector_median_filter_unit vmf_checker u_vmf_checker (.*);
